// ===== sv/msp_rx_pkg.sv =====
// Shared types and constants for the serial request-frame receiver.
`default_nettype none
package msp_rx_pkg;

	localparam int unsigned PAYLOAD_DEPTH_DEF = 64;
	localparam int unsigned APB_AW            = 3;
	localparam int unsigned APB_DW            = 32;
	localparam int unsigned IN_DW             = 8;
	localparam int unsigned OUT_DW            = 32;
	localparam int unsigned OUT_UW            = 2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_LT     = 8'h3C;

	localparam logic [0:0] REG_FRAME_ENABLE = 1'b0;

	typedef enum logic [1:0] {
		KIND_OTHER   = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_EMPTY   = 2'd2
	} msp_kind_t;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_START,
		PS_M,
		PS_ARROW,
		PS_SIZE,
		PS_BODY
	} msp_parse_state_t;

	typedef enum logic {
		EM_IDLE,
		EM_PAY
	} msp_em_state_t;

	typedef struct packed {
		logic       vld;
		msp_kind_t  kind;
		logic [7:0] command;
		logic [7:0] data;
	} msp_req_t;

endpackage
`default_nettype wire

// ===== sv/msp_rx_emit.sv =====
// Payload memory and result sequencer with output register.
`default_nettype none
module msp_rx_emit #(
	parameter int unsigned PAYLOAD_DEPTH = msp_rx_pkg::PAYLOAD_DEPTH_DEF,
	localparam int unsigned SW = $clog2(PAYLOAD_DEPTH + 1),
	localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire msp_rx_pkg::msp_req_t         req,
	input  wire logic [SW-1:0]                req_size,
	output logic                              req_ready,
	input  wire logic                         wr_en,
	input  wire logic [AW-1:0]                wr_addr,
	input  wire logic [7:0]                   wr_data,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// command[7:0], size[14:8], index[20:15], data[28:21], zero[31:29]
	output logic [msp_rx_pkg::OUT_DW-1:0]     m_tdata,
	// kind[1:0]
	output logic [msp_rx_pkg::OUT_UW-1:0]     m_tuser,
	output logic                              m_tlast
);
	import msp_rx_pkg::*;

	logic [7:0]    mem [PAYLOAD_DEPTH];
	logic [7:0]    rd_data_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	msp_em_state_t em_state_q, em_state_d;
	logic [AW-1:0] idx_q;

	logic          req_vld_q;
	msp_kind_t     req_kind_q;
	logic [7:0]    req_cmd_q;
	logic [7:0]    req_data_q;
	logic [SW-1:0] req_size_q;

	logic          o_vld_q;
	msp_kind_t     o_kind_q, o_kind_d;
	logic [7:0]    o_cmd_q, o_cmd_d;
	logic [6:0]    o_size_q, o_size_d;
	logic [5:0]    o_idx_q, o_idx_d;
	logic [7:0]    o_data_q, o_data_d;
	logic          o_last_q, o_last_d;

	logic out_free, load, take, pay_start, pay_adv, pay_last;

	assign out_free  = !o_vld_q || m_tready;
	assign pay_last  = (SW'(idx_q) + SW'(1)) == req_size_q;
	assign req_ready = !req_vld_q && (em_state_q == EM_IDLE);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		em_state_d = em_state_q;
		unique case (em_state_q)
			EM_IDLE: begin
				if (req_vld_q && req_kind_q == KIND_PAYLOAD) begin
					em_state_d = EM_PAY;
				end
			end
			EM_PAY: begin
				if (out_free && pay_last) begin
					em_state_d = EM_IDLE;
				end
			end
			default: em_state_d = EM_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		load      = 1'b0;
		take      = 1'b0;
		pay_start = 1'b0;
		pay_adv   = 1'b0;
		o_kind_d  = req_kind_q;
		o_cmd_d   = req_cmd_q;
		o_size_d  = '0;
		o_idx_d   = '0;
		o_data_d  = req_data_q;
		o_last_d  = 1'b1;
		unique case (em_state_q)
			EM_IDLE: begin
				if (req_vld_q) begin
					if (req_kind_q == KIND_PAYLOAD) begin
						rd_en     = 1'b1;
						take      = 1'b1;
						pay_start = 1'b1;
					end else if (out_free) begin
						load = 1'b1;
						take = 1'b1;
					end
				end
			end
			EM_PAY: begin
				o_kind_d = KIND_PAYLOAD;
				o_size_d = 7'(req_size_q);
				o_idx_d  = 6'(idx_q);
				o_data_d = rd_data_q;
				o_last_d = pay_last;
				if (out_free) begin
					load = 1'b1;
					if (!pay_last) begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
						pay_adv = 1'b1;
					end
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_state_q <= EM_IDLE;
			req_vld_q  <= 1'b0;
			o_vld_q    <= 1'b0;
			idx_q      <= '0;
		end else begin
			em_state_q <= em_state_d;
			if (req.vld) begin
				req_vld_q <= 1'b1;
			end else if (take) begin
				req_vld_q <= 1'b0;
			end
			if (load) begin
				o_vld_q <= 1'b1;
			end else if (m_tready) begin
				o_vld_q <= 1'b0;
			end
			if (pay_start) begin
				idx_q <= '0;
			end else if (pay_adv) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.vld) begin
			req_kind_q <= req.kind;
			req_cmd_q  <= req.command;
			req_data_q <= req.data;
			req_size_q <= req_size;
		end
		if (load) begin
			o_kind_q <= o_kind_d;
			o_cmd_q  <= o_cmd_d;
			o_size_q <= o_size_d;
			o_idx_q  <= o_idx_d;
			o_data_q <= o_data_d;
			o_last_q <= o_last_d;
		end
	end

	assign m_tvalid = o_vld_q;
	assign m_tdata  = {3'b000, o_data_q, o_idx_q, o_size_q, o_cmd_q};
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;

endmodule
`default_nettype wire

// ===== sv/msp_frame_receiver.sv =====
// Top level of the serial request-frame receiver: parser, register port, result stream.
// Received bytes are taken one word per cycle while they produce no result; a word that
// produces a single result (a passed-through byte or an empty frame) fills the one-entry
// request slot ahead of the output register, and no word is taken until the slot empties.
// A checksum byte that closes a good frame starts a burst of size payload words read from
// the payload memory through its read register into the output register, one per cycle
// while the output is taken; no input word is taken until the last one sits in the output
// register. Frame parsing is on after reset; register 0 bit 0 turns it off.
`default_nettype none
module msp_frame_receiver #(
	parameter int unsigned PAYLOAD_DEPTH = msp_rx_pkg::PAYLOAD_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [msp_rx_pkg::APB_AW-1:0] paddr,
	input  wire logic [msp_rx_pkg::APB_DW-1:0] pwdata,
	output logic [msp_rx_pkg::APB_DW-1:0]     prdata,
	output logic                              pready,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// rx_byte[7:0]
	input  wire logic [msp_rx_pkg::IN_DW-1:0] s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// command[7:0], size[14:8], index[20:15], data[28:21], zero[31:29]
	output logic [msp_rx_pkg::OUT_DW-1:0]     m_tdata,
	// kind[1:0]
	output logic [msp_rx_pkg::OUT_UW-1:0]     m_tuser,
	output logic                              m_tlast
);
	import msp_rx_pkg::*;

	localparam int unsigned SW = $clog2(PAYLOAD_DEPTH + 1);
	localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic             enable_q;
	msp_parse_state_t state_q, state_d;
	logic [SW-1:0]    exp_q, exp_d;
	logic [SW-1:0]    cnt_q, cnt_d;
	logic [7:0]       xor_q, xor_d;
	logic [7:0]       cmd_q, cmd_d;

	logic       acc;
	logic [7:0] c;
	logic       too_big, in_body, reg_sel;
	msp_req_t   req;
	logic       req_ready;
	logic       wr_en;

	assign acc     = s_tvalid && s_tready;
	assign c       = s_tdata[7:0];
	assign too_big = 9'(c) > 9'(PAYLOAD_DEPTH);
	assign in_body = cnt_q < exp_q;
	assign reg_sel = paddr[2] == REG_FRAME_ENABLE;

	assign pready   = 1'b1;
	assign prdata   = reg_sel ? {{(APB_DW-1){1'b0}}, enable_q} : '0;
	assign s_tready = req_ready;

	always_comb begin
		state_d = state_q;
		if (acc) begin
			if (!enable_q) begin
				state_d = PS_IDLE;
			end else begin
				unique case (state_q)
					PS_IDLE:  state_d = (c == CH_DOLLAR) ? PS_START : PS_IDLE;
					PS_START: state_d = (c == CH_M) ? PS_M : PS_IDLE;
					PS_M:     state_d = (c == CH_LT) ? PS_ARROW : PS_IDLE;
					PS_ARROW: state_d = too_big ? PS_IDLE : PS_SIZE;
					PS_SIZE:  state_d = PS_BODY;
					PS_BODY:  state_d = in_body ? PS_BODY : PS_IDLE;
					default:  state_d = PS_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		exp_d       = exp_q;
		cnt_d       = cnt_q;
		xor_d       = xor_q;
		cmd_d       = cmd_q;
		wr_en       = 1'b0;
		req.vld     = 1'b0;
		req.kind    = KIND_OTHER;
		req.command = '0;
		req.data    = c;
		if (acc) begin
			if (!enable_q) begin
				req.vld = 1'b1;
			end else begin
				unique case (state_q)
					PS_IDLE: begin
						req.vld = (c != CH_DOLLAR);
					end
					PS_ARROW: begin
						if (!too_big) begin
							exp_d = SW'(c);
							cnt_d = '0;
							xor_d = c;
						end
					end
					PS_SIZE: begin
						cmd_d = c;
						xor_d = xor_q ^ c;
					end
					PS_BODY: begin
						if (in_body) begin
							xor_d = xor_q ^ c;
							wr_en = 1'b1;
							cnt_d = cnt_q + SW'(1);
						end else if (xor_q == c) begin
							req.vld     = 1'b1;
							req.command = cmd_q;
							if (exp_q == '0) begin
								req.kind = KIND_EMPTY;
								req.data = '0;
							end else begin
								req.kind = KIND_PAYLOAD;
							end
						end
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			state_q  <= PS_IDLE;
			exp_q    <= '0;
			cnt_q    <= '0;
			xor_q    <= '0;
			cmd_q    <= '0;
		end else begin
			if (psel && penable && pwrite && pready && reg_sel) begin
				enable_q <= pwdata[0];
			end
			state_q <= state_d;
			exp_q   <= exp_d;
			cnt_q   <= cnt_d;
			xor_q   <= xor_d;
			cmd_q   <= cmd_d;
		end
	end

	msp_rx_emit #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_size  (exp_q),
		.req_ready (req_ready),
		.wr_en     (wr_en),
		.wr_addr   (cnt_q[AW-1:0]),
		.wr_data   (c),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
